// ===== src/icaf_pkg.sv =====
// Shared types, constants and the arctangent table of the attitude filter.
// No dependencies; every other file of the block but icaf_isqrt uses this package.
package icaf_pkg;

  // Iteration defaults and table length
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN = 28;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_BLEND_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_STEP_TIME    = 2'd1;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [15:0] STEP_TIME_RST    = 16'd1311;

  // Angles: pi in Q3.29 and in Q2.30 (also two pi in Q3.29)
  localparam logic signed [34:0] PI29     = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI29 = 35'sd3373259426;
  localparam logic signed [34:0] PI30     = 35'sd3373259426;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } icaf_in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } icaf_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_RX, ST_M_RY, ST_M_RZ, ST_M_AY, ST_M_AZ, ST_SUMSQ, ST_WRAP,
    ST_ROLL_GO, ST_ROLL_RUN, ST_SQRT_WAIT, ST_PITCH_GO, ST_PITCH_RUN,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_OUT
  } icaf_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_M_RX, OP_M_RY, OP_M_RZ, OP_M_AY, OP_M_AZ, OP_SUMSQ,
    OP_WRAP, OP_ROLL_GO, OP_ROLL_WAIT, OP_PITCH_GO, OP_PITCH_WAIT,
    OP_B0, OP_B1, OP_B2, OP_B3, OP_B4, OP_COMMIT
  } icaf_op_t;

  typedef struct packed {
    icaf_op_t op;
  } icaf_cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic sqrt_busy;
    logic yaw_ok;
  } icaf_stat_t;

  // Truncated arctangent of 2^-i in Q2.30
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/icaf_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle, 30 steps.
// Depends on nothing outside this file.
module icaf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [59:0] radicand,
  output logic        busy,
  output logic [30:0] root
);

  localparam logic [4:0] LAST = 5'd29;

  logic [60:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [60:0] trial;

  assign trial = res_r + bit_r;

  // One digit per cycle
  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      v_nxt    = {1'b0, radicand};
      res_nxt  = '0;
      bit_nxt  = 61'd1 << 58;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == LAST) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[30:0];

endmodule

// ===== src/icaf_cordic.sv =====
// Iterative CORDIC vectoring unit: atan2(y, x) in Q3.29, one step per cycle.
// Depends on icaf_pkg for the arctangent table and pi.
module icaf_cordic #(
  parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] x_in,
  output logic               busy,
  output logic signed [33:0] z_out
);
  import icaf_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST = 5'(NSTEPS - 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [34:0] z_r, z_nxt, ang, z_half;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, zero_r, zero_nxt;
  logic signed [33:0] sh_x, sh_y;

  assign sh_x = x_r >>> cnt_r;
  assign sh_y = y_r >>> cnt_r;
  assign ang  = $signed({5'b0, atan_entry(cnt_r)});

  // Pre-rotation on start, then one micro-rotation per cycle
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      if (x_in[33]) begin
        x_nxt = -x_in;
        y_nxt = -y_in;
        z_nxt = y_in[33] ? -PI30 : PI30;
      end else begin
        x_nxt = x_in;
        y_nxt = y_in;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (!y_r[33]) begin
        x_nxt = x_r + sh_y;
        y_nxt = y_r - sh_x;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - sh_y;
        y_nxt = y_r + sh_x;
        z_nxt = z_r - ang;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == LAST) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  assign z_half = z_r >>> 1;
  assign busy   = busy_r;
  assign z_out  = zero_r ? '0 : z_half[33:0];

endmodule

// ===== src/icaf_dp.sv =====
// Datapath: config registers, angle state, shared multiplier, yaw wrap,
// and the square root and CORDIC units. Depends on icaf_pkg, icaf_isqrt and icaf_cordic.
module icaf_dp #(
  parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  icaf_pkg::icaf_cmd_t cmd,
  output icaf_pkg::icaf_stat_t stat,
  input  icaf_pkg::icaf_in_t  in_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output icaf_pkg::icaf_out_t out_word
);
  import icaf_pkg::*;

  logic [15:0]        alpha_r, dt_r;
  icaf_in_t           in_r;
  icaf_out_t          out_r;
  logic signed [51:0] prod_r, bacc_r, bsum;
  logic signed [31:0] roll_acc_r, pitch_acc_r, yaw_acc_r, roll_t_r, pitch_t_r;
  logic signed [34:0] yaw_t_r;
  logic [31:0]        sumsq_r;
  logic signed [33:0] tilt_roll_r, tilt_pitch_r;
  logic signed [17:0] ma;
  logic signed [33:0] mb;
  logic [16:0]        beta;
  logic signed [16:0] nax;
  logic signed [33:0] roll_sum, pitch_sum;
  logic signed [34:0] yaw_sum;
  logic               yaw_ok;

  logic               c_start, c_busy, s_start, s_busy;
  logic signed [33:0] c_y, c_x, c_z;
  logic [30:0]        s_root;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  // Round to Q3.13 and saturate
  function automatic logic signed [15:0] to_out(input logic signed [31:0] a);
    logic signed [32:0] t;
    logic signed [16:0] s;
    logic signed [15:0] r;
    t = {a[31], a} + 33'sd32768;
    s = t[32:16];
    if (s > 17'sd32767)       r = 16'sh7FFF;
    else if (s < -17'sd32768) r = 16'sh8000;
    else                      r = s[15:0];
    return r;
  endfunction

  assign beta = 17'h10000 - {1'b0, alpha_r};
  assign nax  = -{in_r.accel_x[15], in_r.accel_x};

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_M_RX: begin
        ma = {2'b00, dt_r};
        mb = {{18{in_r.rate_x[15]}}, in_r.rate_x};
      end
      OP_M_RY: begin
        ma = {2'b00, dt_r};
        mb = {{18{in_r.rate_y[15]}}, in_r.rate_y};
      end
      OP_M_RZ: begin
        ma = {2'b00, dt_r};
        mb = {{18{in_r.rate_z[15]}}, in_r.rate_z};
      end
      OP_M_AY: begin
        ma = {{2{in_r.accel_y[15]}}, in_r.accel_y};
        mb = {{18{in_r.accel_y[15]}}, in_r.accel_y};
      end
      OP_M_AZ: begin
        ma = {{2{in_r.accel_z[15]}}, in_r.accel_z};
        mb = {{18{in_r.accel_z[15]}}, in_r.accel_z};
      end
      OP_B0: begin
        ma = {2'b00, alpha_r};
        mb = {{2{roll_t_r[31]}}, roll_t_r};
      end
      OP_B1: begin
        ma = {1'b0, beta};
        mb = tilt_roll_r;
      end
      OP_B2: begin
        ma = {2'b00, alpha_r};
        mb = {{2{pitch_t_r[31]}}, pitch_t_r};
      end
      OP_B3: begin
        ma = {1'b0, beta};
        mb = tilt_pitch_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Integration sums: twice the rate product is the Q.29 increment
  assign roll_sum  = {{2{roll_acc_r[31]}}, roll_acc_r} + {prod_r[32:0], 1'b0};
  assign pitch_sum = {{2{pitch_acc_r[31]}}, pitch_acc_r} + {prod_r[32:0], 1'b0};
  assign yaw_sum   = {{3{yaw_acc_r[31]}}, yaw_acc_r} + {prod_r[33:0], 1'b0};
  assign bsum      = bacc_r + prod_r;
  assign yaw_ok    = (yaw_t_r < PI29) && (yaw_t_r >= -PI29);

  // Unit start and operand select
  assign s_start = (cmd.op == OP_ROLL_GO);
  assign c_start = (cmd.op == OP_ROLL_GO) || (cmd.op == OP_PITCH_GO);
  assign c_y = (cmd.op == OP_PITCH_GO) ? {{3{nax[16]}}, nax, 14'b0}
                                       : {{4{in_r.accel_y[15]}}, in_r.accel_y, 14'b0};
  assign c_x = (cmd.op == OP_PITCH_GO) ? {3'b000, s_root}
                                       : {{4{in_r.accel_z[15]}}, in_r.accel_z, 14'b0};

  icaf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (s_start),
    .radicand ({sumsq_r, 28'b0}),
    .busy     (s_busy),
    .root     (s_root)
  );

  icaf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .busy  (c_busy),
    .z_out (c_z)
  );

  // Configuration registers and angle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= BLEND_WEIGHT_RST;
      dt_r        <= STEP_TIME_RST;
      roll_acc_r  <= '0;
      pitch_acc_r <= '0;
      yaw_acc_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLEND_WEIGHT: alpha_r <= cfg_data;
          CFG_STEP_TIME:    dt_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_COMMIT) begin
        roll_acc_r  <= roll_t_r;
        pitch_acc_r <= pitch_t_r;
        yaw_acc_r   <= yaw_t_r[31:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (cmd.op)
      OP_LOAD:       in_r <= in_word;
      OP_M_RY:       roll_t_r <= sat32({{2{roll_sum[33]}}, roll_sum});
      OP_M_RZ:       pitch_t_r <= sat32({{2{pitch_sum[33]}}, pitch_sum});
      OP_M_AY:       yaw_t_r <= yaw_sum;
      OP_M_AZ:       sumsq_r <= prod_r[31:0];
      OP_SUMSQ:      sumsq_r <= sumsq_r + prod_r[31:0];
      OP_WRAP: begin
        if (yaw_t_r >= PI29)       yaw_t_r <= yaw_t_r - TWO_PI29;
        else if (yaw_t_r < -PI29)  yaw_t_r <= yaw_t_r + TWO_PI29;
      end
      OP_ROLL_WAIT:  tilt_roll_r <= c_z;
      OP_PITCH_WAIT: tilt_pitch_r <= c_z;
      OP_B1:         bacc_r <= prod_r;
      OP_B2:         roll_t_r <= sat32(bsum[51:16]);
      OP_B3:         bacc_r <= prod_r;
      OP_B4:         pitch_t_r <= sat32(bsum[51:16]);
      OP_COMMIT: begin
        out_r.roll_angle  <= to_out(roll_t_r);
        out_r.pitch_angle <= to_out(pitch_t_r);
        out_r.yaw_angle   <= to_out(yaw_t_r[31:0]);
      end
      default: ;
    endcase
  end

  assign stat.cordic_busy = c_busy;
  assign stat.sqrt_busy   = s_busy;
  assign stat.yaw_ok      = yaw_ok;
  assign out_word         = out_r;

endmodule

// ===== src/icaf_ctrl.sv =====
// Controller: sequences one sample through the datapath and owns the
// handshakes of both channels. Depends on icaf_pkg.
module icaf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  icaf_pkg::icaf_stat_t stat,
  output icaf_pkg::icaf_cmd_t  cmd
);
  import icaf_pkg::*;

  icaf_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        commit;

  // Output register is free when empty or being taken
  assign commit = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_M_RX;
      ST_M_RX:      state_nxt = ST_M_RY;
      ST_M_RY:      state_nxt = ST_M_RZ;
      ST_M_RZ:      state_nxt = ST_M_AY;
      ST_M_AY:      state_nxt = ST_M_AZ;
      ST_M_AZ:      state_nxt = ST_SUMSQ;
      ST_SUMSQ:     state_nxt = ST_WRAP;
      ST_WRAP:      if (stat.yaw_ok) state_nxt = ST_ROLL_GO;
      ST_ROLL_GO:   state_nxt = ST_ROLL_RUN;
      ST_ROLL_RUN:  if (!stat.cordic_busy) state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (!stat.sqrt_busy) state_nxt = ST_PITCH_GO;
      ST_PITCH_GO:  state_nxt = ST_PITCH_RUN;
      ST_PITCH_RUN: if (!stat.cordic_busy) state_nxt = ST_B0;
      ST_B0:        state_nxt = ST_B1;
      ST_B1:        state_nxt = ST_B2;
      ST_B2:        state_nxt = ST_B3;
      ST_B3:        state_nxt = ST_B4;
      ST_B4:        state_nxt = ST_OUT;
      ST_OUT:       if (commit) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd.op   = OP_NONE;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.op   = in_valid ? OP_LOAD : OP_NONE;
      end
      ST_M_RX:      cmd.op = OP_M_RX;
      ST_M_RY:      cmd.op = OP_M_RY;
      ST_M_RZ:      cmd.op = OP_M_RZ;
      ST_M_AY:      cmd.op = OP_M_AY;
      ST_M_AZ:      cmd.op = OP_M_AZ;
      ST_SUMSQ:     cmd.op = OP_SUMSQ;
      ST_WRAP:      cmd.op = OP_WRAP;
      ST_ROLL_GO:   cmd.op = OP_ROLL_GO;
      ST_ROLL_RUN:  cmd.op = OP_ROLL_WAIT;
      ST_SQRT_WAIT: cmd.op = OP_NONE;
      ST_PITCH_GO:  cmd.op = OP_PITCH_GO;
      ST_PITCH_RUN: cmd.op = OP_PITCH_WAIT;
      ST_B0:        cmd.op = OP_B0;
      ST_B1:        cmd.op = OP_B1;
      ST_B2:        cmd.op = OP_B2;
      ST_B3:        cmd.op = OP_B3;
      ST_B4:        cmd.op = OP_B4;
      ST_OUT:       cmd.op = commit ? OP_COMMIT : OP_NONE;
      default:      cmd.op = OP_NONE;
    endcase
  end

  // Result word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit)                        out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/imu_complementary_attitude_filter.sv =====
// Top level of the complementary attitude filter: controller plus datapath.
// Depends on icaf_pkg, icaf_ctrl, icaf_dp (with icaf_isqrt, icaf_cordic).
//
// One IMU sample word in, one angle word out. The block takes a sample when
// idle and takes no new one until it has committed the last. Yaw is wrapped
// by two pi as often as needed. The 30-step bit-serial square root runs
// beside the roll CORDIC pass, followed by the pitch CORDIC pass and the
// blend multiplies on one shared multiplier. A finished word waits in the
// output register while the next sample is already taken. Configuration is
// to be written only while idle; the block itself does not enforce this.
module imu_complementary_attitude_filter #(
  parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  icaf_pkg::icaf_in_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output icaf_pkg::icaf_out_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import icaf_pkg::*;

  icaf_cmd_t  cmd;
  icaf_stat_t stat;

  icaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  icaf_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (out_word)
  );

endmodule

// ===== src/icaf_checker.sv =====
// Port-level checks of the attitude filter, bound to the top level.
// Depends on icaf_pkg and imu_complementary_attitude_filter.
module icaf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input icaf_pkg::icaf_out_t out_word
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  // Taking a sample makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sample taken without going busy");

  // A new result only appears at the end of processing
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Yaw stays wrapped
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.yaw_angle >= -16'sd25736) &&
                  (out_word.yaw_angle <= 16'sd25736))
    else $error("yaw outside wrap range");

endmodule

bind imu_complementary_attitude_filter icaf_checker u_icaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
